@@ design/oxs_pkg.sv @@
// package for the statistics tlv parser
// shared types and constants; no dependencies
`default_nettype none
package oxs_pkg;
  localparam logic [15:0] ClassBasic = 16'h8002;
  localparam logic [15:0] ClassExp   = 16'hFFFF;
  localparam int QueueDepth = 2;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  // result record
  typedef struct packed {
    logic        status;
    logic [16:0] block_len;
    logic [31:0] dur_secs;
    logic [31:0] dur_nsecs;
    logic [31:0] idle_secs;
    logic [63:0] pkt_total;
    logic [63:0] octet_total;
    logic [31:0] flow_total;
    logic [7:0]  present_mask;
  } result_t;

  function automatic logic [63:0] hdr_of(input logic [6:0] f, input logic [7:0] l);
    hdr_of = {ClassBasic, f, 1'b0, l, 32'h0};
  endfunction
endpackage
`default_nettype wire

@@ design/oxs_queue.sv @@
// short request queue between front and back
// depends on oxs_pkg
`default_nettype none
module oxs_queue import oxs_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  wire byte_req_t wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output byte_req_t      rd_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  byte_req_t mem [Depth];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;
  logic push, pop;

  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  assign wr_ready = count != (AW+1)'(Depth);
  assign rd_valid = count != '0;
  assign rd_data = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        mem[wptr] <= wr_data;
        wptr <= (wptr == AW'(Depth-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) rptr <= (rptr == AW'(Depth-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(Depth))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) (count == '0) |-> !rd_valid)
    else $error("empty queue shows data");
  assert property (@(posedge clk) disable iff (rst) push && !pop |=> count == $past(count) + 1'b1)
    else $error("push lost");
endmodule
`default_nettype wire

@@ design/oxs_back.sv @@
// back end: tlv state machine and result register
// depends on oxs_pkg
`default_nettype none
module oxs_back import oxs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire byte_req_t req,
  output logic           res_valid,
  input  wire logic      res_ready,
  output result_t        res
);
  typedef enum logic [1:0] {PH_HDR, PH_EHDR, PH_PAY, PH_PAD} phase_t;

  phase_t      phase, phase_next;
  logic [16:0] block_count, block_count_next;
  logic [15:0] declared_len, declared_len_next;
  logic [63:0] entry_header, entry_header_next;
  logic [3:0]  entry_count, entry_count_next;
  logic [7:0]  payload_left, payload_left_next;
  logic [63:0] payload_acc, payload_acc_next;
  logic [31:0] s_sec, s_nsec, s_idle, s_flow;
  logic [63:0] s_pkt, s_byte;
  logic [31:0] s_sec_next, s_nsec_next, s_idle_next, s_flow_next;
  logic [63:0] s_pkt_next, s_byte_next;
  logic [7:0]  mask_reg, mask_next;
  logic        reported, reported_next;
  logic        emit_ok, emit_err;
  logic        take;
  logic [16:0] padded;
  logic [16:0] left;

  // one request per cycle whenever the result slot is free or draining
  assign req_ready = !res_valid || res_ready;
  assign take = req_valid && req_ready;
  assign left = {1'b0, declared_len} - block_count;

  // per-byte step
  always_comb begin
    logic [63:0] h;
    logic [7:0]  len, pl;
    logic        ex, dec;
    phase_next = phase;
    block_count_next = block_count;
    declared_len_next = declared_len;
    entry_header_next = entry_header;
    entry_count_next = entry_count;
    payload_left_next = payload_left;
    payload_acc_next = payload_acc;
    s_sec_next = s_sec; s_nsec_next = s_nsec; s_idle_next = s_idle;
    s_flow_next = s_flow; s_pkt_next = s_pkt; s_byte_next = s_byte;
    mask_next = mask_reg;
    emit_ok = 1'b0;
    emit_err = 1'b0;
    padded = '0;
    h = '0; len = '0; pl = '0; ex = 1'b0; dec = 1'b0;
    if (!reported) begin
      case (phase)
        PH_HDR: begin
          if (block_count >= 17'd2) declared_len_next = {declared_len[7:0], req.data};
          block_count_next = block_count + 1'b1;
          if (block_count_next == 17'd4) begin
            if (declared_len_next < 16'd4) emit_err = 1'b1;
            else phase_next = PH_EHDR;
          end
        end
        PH_EHDR: begin
          if (entry_count == '0 && (left[16] || left < 17'd4)) begin
            emit_err = 1'b1;
          end else begin
            h = (entry_count == '0) ? {56'h0, req.data} : {entry_header[55:0], req.data};
            entry_header_next = h;
            entry_count_next = entry_count + 1'b1;
            block_count_next = block_count + 1'b1;
            if (entry_count_next == 4'd4) begin
              if (h[31:16] == ClassExp) begin
                if (({1'b0, declared_len} - block_count_next) < 17'd4 ||
                    block_count_next > {1'b0, declared_len}) emit_err = 1'b1;
              end else begin
                h = {h[31:0], 32'h0};
                ex = 1'b1;
              end
            end else if (entry_count_next >= 4'd8) begin
              ex = 1'b1;
            end
            // header complete
            if (ex) begin
              len = h[39:32];
              if (h[63:48] == ClassExp && len < 8'd4) emit_err = 1'b1;
              else begin
                pl = (h[63:48] == ClassExp) ? len - 8'd4 : len;
                if ({9'h0, pl} > ({1'b0, declared_len} - block_count_next) ||
                    block_count_next > {1'b0, declared_len}) emit_err = 1'b1;
                else begin
                  entry_header_next = h;
                  entry_count_next = '0;
                  payload_acc_next = '0;
                  if (pl == '0) dec = 1'b1;
                  else begin
                    payload_left_next = pl;
                    phase_next = PH_PAY;
                  end
                end
              end
            end
          end
        end
        PH_PAY: begin
          payload_acc_next = {payload_acc[55:0], req.data};
          block_count_next = block_count + 1'b1;
          if (payload_left != '0) payload_left_next = payload_left - 1'b1;
          if (payload_left_next == '0) begin
            dec = 1'b1;
            phase_next = PH_EHDR;
          end
        end
        default: block_count_next = block_count + 1'b1;
      endcase
      // padded length from the length as it stands after this byte
      padded = ({1'b0, declared_len_next} + 17'd7) & ~17'd7;
      // decode a finished basic entry
      if (dec) begin
        if (entry_header_next == hdr_of(7'd0, 8'd8)) begin
          s_sec_next = payload_acc_next[63:32]; s_nsec_next = payload_acc_next[31:0];
          mask_next[0] = 1'b1;
        end else if (entry_header_next == hdr_of(7'd1, 8'd8)) begin
          s_idle_next = payload_acc_next[63:32]; mask_next[1] = 1'b1;
        end else if (entry_header_next == hdr_of(7'd3, 8'd4)) begin
          s_flow_next = payload_acc_next[31:0]; mask_next[3] = 1'b1;
        end else if (entry_header_next == hdr_of(7'd4, 8'd8)) begin
          s_pkt_next = payload_acc_next; mask_next[4] = 1'b1;
        end else if (entry_header_next == hdr_of(7'd5, 8'd8)) begin
          s_byte_next = payload_acc_next; mask_next[5] = 1'b1;
        end
      end
      // end of entry, block header or padding byte
      if (!emit_err && (dec || (phase == PH_HDR && phase_next == PH_EHDR) ||
                        phase == PH_PAD)) begin
        if (block_count_next >= {1'b0, declared_len_next}) phase_next = PH_PAD;
        if (phase_next == PH_PAD && block_count_next >= padded) emit_ok = 1'b1;
      end
    end
    if (req.last && !reported && !emit_ok) emit_err = 1'b1;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR;
      block_count <= '0;
      declared_len <= '0;
      entry_header <= '0;
      entry_count <= '0;
      payload_left <= '0;
      payload_acc <= '0;
      {s_sec, s_nsec, s_idle, s_flow} <= '1;
      {s_pkt, s_byte} <= '1;
      mask_reg <= '0;
      reported <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take && (emit_ok || emit_err)) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      if (take) begin
        if (emit_ok || emit_err) begin
          res.status <= emit_err;
          res.block_len <= emit_err ? '0 : padded;
          res.dur_secs <= emit_err ? '1 : s_sec_next;
          res.dur_nsecs <= emit_err ? '1 : s_nsec_next;
          res.idle_secs <= emit_err ? '1 : s_idle_next;
          res.pkt_total <= emit_err ? '1 : s_pkt_next;
          res.octet_total <= emit_err ? '1 : s_byte_next;
          res.flow_total <= emit_err ? '1 : s_flow_next;
          res.present_mask <= emit_err ? '0 : mask_next;
        end
        if (req.last) begin
          phase <= PH_HDR;
          block_count <= '0;
          declared_len <= '0;
          entry_header <= '0;
          entry_count <= '0;
          payload_left <= '0;
          payload_acc <= '0;
          {s_sec, s_nsec, s_idle, s_flow} <= '1;
          {s_pkt, s_byte} <= '1;
          mask_reg <= '0;
          reported <= 1'b0;
        end else begin
          phase <= phase_next;
          block_count <= block_count_next;
          declared_len <= declared_len_next;
          entry_header <= entry_header_next;
          entry_count <= entry_count_next;
          payload_left <= payload_left_next;
          payload_acc <= payload_acc_next;
          s_sec <= s_sec_next; s_nsec <= s_nsec_next; s_idle <= s_idle_next;
          s_flow <= s_flow_next; s_pkt <= s_pkt_next; s_byte <= s_byte_next;
          mask_reg <= mask_next;
          reported <= reported || emit_ok || emit_err;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_valid && !res_ready |=> res_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) take && req.last |=> !reported)
    else $error("buffer end did not clear");
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status |-> res.present_mask == '0)
    else $error("error result carries mask");
endmodule
`default_nettype wire

@@ design/oxs_stats_tlv_parser_top.sv @@
// statistics tlv parser top level: request queue and back end
// depends on oxs_pkg, oxs_queue, oxs_back
//
// usage: one byte request per handshake on in_valid/in_ready with in_byte
// and buffer_end. one result per block on out_valid/out_ready: the parse
// status, padded block length, decoded statistics and the present mask.
// throughput: one byte per cycle while the result slot is free or draining,
// set by the byte step of the back end. a byte accepted is written into
// the queue, then read from it by the back end, whose byte step loads the
// result register that drives out_valid.
// reset clears the queue, parser state and result valid flag; the next
// byte starts a block header.
// when the receiver stalls the result waits in its register; the back end
// goes on only while the slot is free or draining, and the queue takes up
// to two more bytes before in_ready falls.
`default_nettype none
module oxs_stats_tlv_parser_top import oxs_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        buffer_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status,
  output logic [16:0]      block_len,
  output logic [31:0]      dur_secs,
  output logic [31:0]      dur_nsecs,
  output logic [31:0]      idle_secs,
  output logic [63:0]      pkt_total,
  output logic [63:0]      octet_total,
  output logic [31:0]      flow_total,
  output logic [7:0]       present_mask
);
  byte_req_t wr, rd;
  logic rd_valid, rd_ready;
  result_t res;

  assign wr.data = in_byte;
  assign wr.last = buffer_end;

  // front: request queue
  oxs_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst, .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(wr),
    .rd_valid, .rd_ready, .rd_data(rd)
  );

  // back: parser
  oxs_back u_back (
    .clk, .rst, .req_valid(rd_valid), .req_ready(rd_ready), .req(rd),
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign status = res.status;
  assign block_len = res.block_len;
  assign dur_secs = res.dur_secs;
  assign dur_nsecs = res.dur_nsecs;
  assign idle_secs = res.idle_secs;
  assign pkt_total = res.pkt_total;
  assign octet_total = res.octet_total;
  assign flow_total = res.flow_total;
  assign present_mask = res.present_mask;
endmodule
`default_nettype wire
